// File: src/pru_pkg.sv
// Shared types and constants for the pixel replicating upscaler.
package pru_pkg;

    localparam int FACTOR_W   = 7;
    localparam int WIDTH_W    = 13;
    localparam int PAD_W      = 2;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int OUT_USER_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_FACTOR = 1'b0,
        REG_ROW_WIDTH    = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_PULL = 1'b1
    } func_t;

    // Decision taken for one accepted item, passed from the sequencer.
    typedef struct packed {
        logic               load_taken;
        logic               out_valid;
        logic               is_pad;
        logic               row_end;
        logic               wr_en;
        logic               rd_en;
        logic [WIDTH_W-1:0] index;
    } step_t;

endpackage

// File: src/pru_seq.sv
// Fill and replay counters of the upscaler, one decision per accepted item.
module pru_seq #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_FACTOR = 100
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  pru_pkg::func_t                 func,
    input  logic [pru_pkg::FACTOR_W-1:0]   scale_factor,
    input  logic [pru_pkg::WIDTH_W-1:0]    row_width,
    output pru_pkg::step_t                 step
);
    import pru_pkg::*;

    logic [WIDTH_W-1:0]  fill_count_reg,   fill_count_next;
    logic                replaying_reg,    replaying_next;
    logic [WIDTH_W-1:0]  column_index_reg, column_index_next;
    logic [FACTOR_W-1:0] pixel_repeat_reg, pixel_repeat_next;
    logic [FACTOR_W-1:0] row_repeat_reg,   row_repeat_next;
    logic [PAD_W-1:0]    pad_count_reg,    pad_count_next;
    logic                in_padding_reg,   in_padding_next;

    logic [FACTOR_W-1:0] eff_factor;
    logic [WIDTH_W-1:0]  eff_width;
    logic [PAD_W-1:0]    pads;
    logic [WIDTH_W:0]    fill_inc;
    logic [WIDTH_W:0]    col_inc;
    logic [FACTOR_W:0]   pix_inc;
    logic [FACTOR_W:0]   row_inc;
    logic [PAD_W:0]      pad_inc;

    always_comb
    begin
        if (scale_factor == '0)
            eff_factor = FACTOR_W'(1);
        else if (int'(scale_factor) > MAX_FACTOR)
            eff_factor = FACTOR_W'(MAX_FACTOR);
        else
            eff_factor = scale_factor;

        if (row_width == '0)
            eff_width = WIDTH_W'(1);
        else if (int'(row_width) > MAX_WIDTH)
            eff_width = WIDTH_W'(MAX_WIDTH);
        else
            eff_width = row_width;
    end

    // Only the low two bits of width times factor decide the padding.
    assign pads     = PAD_W'(eff_width[PAD_W-1:0] * eff_factor[PAD_W-1:0]);
    assign fill_inc = {1'b0, fill_count_reg} + 1'b1;
    assign col_inc  = {1'b0, column_index_reg} + 1'b1;
    assign pix_inc  = {1'b0, pixel_repeat_reg} + 1'b1;
    assign row_inc  = {1'b0, row_repeat_reg} + 1'b1;
    assign pad_inc  = {1'b0, pad_count_reg} + 1'b1;

    always_comb
    begin
        logic finish;
        finish            = 1'b0;
        step              = '0;
        fill_count_next   = fill_count_reg;
        replaying_next    = replaying_reg;
        column_index_next = column_index_reg;
        pixel_repeat_next = pixel_repeat_reg;
        row_repeat_next   = row_repeat_reg;
        pad_count_next    = pad_count_reg;
        in_padding_next   = in_padding_reg;

        if (accept)
        begin
            unique case (func)
                FUNC_LOAD:
                begin
                    if (!replaying_reg)
                    begin
                        step.load_taken = 1'b1;
                        step.wr_en      = (int'(fill_count_reg) < MAX_WIDTH);
                        step.index      = fill_count_reg;
                        fill_count_next = WIDTH_W'(fill_inc);
                        if (fill_inc >= {1'b0, eff_width})
                        begin
                            replaying_next    = 1'b1;
                            column_index_next = '0;
                            pixel_repeat_next = '0;
                            row_repeat_next   = '0;
                            pad_count_next    = '0;
                            in_padding_next   = 1'b0;
                        end
                    end
                end
                FUNC_PULL:
                begin
                    if (replaying_reg)
                    begin
                        step.out_valid = 1'b1;
                        if (in_padding_reg)
                        begin
                            step.is_pad    = 1'b1;
                            pad_count_next = PAD_W'(pad_inc);
                            if (pad_inc >= {1'b0, pads})
                            begin
                                step.row_end = 1'b1;
                                finish       = 1'b1;
                            end
                        end
                        else
                        begin
                            step.rd_en = 1'b1;
                            step.index = column_index_reg;
                            if (pix_inc < {1'b0, eff_factor})
                                pixel_repeat_next = FACTOR_W'(pix_inc);
                            else
                            begin
                                pixel_repeat_next = '0;
                                if (col_inc < {1'b0, eff_width})
                                    column_index_next = WIDTH_W'(col_inc);
                                else if (pads != '0)
                                begin
                                    column_index_next = '0;
                                    in_padding_next   = 1'b1;
                                    pad_count_next    = '0;
                                end
                                else
                                begin
                                    step.row_end = 1'b1;
                                    finish       = 1'b1;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // End of an output row: next replayed row, or back to loading.
        if (finish)
        begin
            in_padding_next   = 1'b0;
            pad_count_next    = '0;
            column_index_next = '0;
            pixel_repeat_next = '0;
            if (row_inc < {1'b0, eff_factor})
                row_repeat_next = FACTOR_W'(row_inc);
            else
            begin
                row_repeat_next = '0;
                replaying_next  = 1'b0;
                fill_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg   <= '0;
            replaying_reg    <= 1'b0;
            column_index_reg <= '0;
            pixel_repeat_reg <= '0;
            row_repeat_reg   <= '0;
            pad_count_reg    <= '0;
            in_padding_reg   <= 1'b0;
        end
        else
        begin
            fill_count_reg   <= fill_count_next;
            replaying_reg    <= replaying_next;
            column_index_reg <= column_index_next;
            pixel_repeat_reg <= pixel_repeat_next;
            row_repeat_reg   <= row_repeat_next;
            pad_count_reg    <= pad_count_next;
            in_padding_reg   <= in_padding_next;
        end
    end

    a_pad_only_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
        in_padding_reg |-> replaying_reg)
        else $error("padding phase outside a replay");

    a_pad_count_in_padding: assert property (@(posedge clk) disable iff (!rst_n)
        (pad_count_reg != '0) |-> in_padding_reg)
        else $error("pad count running outside the padding phase");

    a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !replaying_reg |-> (column_index_reg == '0 && pixel_repeat_reg == '0
                            && row_repeat_reg == '0))
        else $error("replay counters not cleared while loading");

endmodule

// File: src/pixel_replicating_upscaler_unit.sv
// An accepted item goes through stage 1 and then the output register, which drives m_tvalid.
// Throughput: one item per cycle unless m_tready stalls the output; the sequencer is
// combinational and the line buffer takes one write or one read per cycle, with its read data registered.
// Reset clears counters, pipeline valids and registers (factor 1, width 1) at once;
// the line buffer is not cleared, so no clearing pass is needed after reset.
// The configuration channel is always ready.
module pixel_replicating_upscaler_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_FACTOR = 100
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input items.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pru_pkg::PIX_W-1:0]         s_tdata,   // in_blue, in_green, in_red
    input  logic                              s_tuser,   // func
    // Result items.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pru_pkg::PIX_W-1:0]         m_tdata,   // out_blue, out_green, out_red
    output logic [pru_pkg::OUT_USER_W-1:0]    m_tuser,   // load_taken, out_valid, out_is_pad
    output logic                              m_tlast,   // row_end
    // Register writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pru_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pru_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pru_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Configuration registers.
    logic [FACTOR_W-1:0] scale_factor_reg;
    logic [WIDTH_W-1:0]  row_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_factor_reg <= FACTOR_W'(1);
            row_width_reg    <= WIDTH_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SCALE_FACTOR: scale_factor_reg <= cfg_data[FACTOR_W-1:0];
                REG_ROW_WIDTH:    row_width_reg    <= cfg_data[WIDTH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Pipeline: stage 1 waits for the line buffer read, then the output register.
    logic    s1_valid_reg, s1_valid_next;
    step_t   s1_step_reg;
    logic    m_valid_reg, m_valid_next;
    logic    s1_move;
    logic    accept;
    step_t   step;

    // Stage 1 may move on when the output register is empty or being drained.
    assign s1_move  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_move;
    assign accept   = s_tvalid && s_tready;

    pru_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .func         (func_t'(s_tuser)),
        .scale_factor (scale_factor_reg),
        .row_width    (row_width_reg),
        .step         (step)
    );

    // Line buffer: one write port for loads, one registered read port for replay.
    // Loads only happen while loading and reads only while replaying, so a
    // write and a read never meet in the same cycle.
    logic [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_data_reg;
    logic [AW-1:0]    mem_addr;

    assign mem_addr = AW'(step.index);

    always_ff @(posedge clk)
    begin
        if (step.wr_en)
            line_mem[mem_addr] <= s_tdata;
        if (step.rd_en)
            rd_data_reg <= line_mem[mem_addr];
    end

    // Read data is only captured on an accepted pixel request, so it stays put
    // while stage 1 is held behind a stalled output.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        m_valid_next  = m_valid_reg;
        if (s_tready)
            s1_valid_next = accept;
        if (s1_move)
            m_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    logic [PIX_W-1:0]      m_data_reg;
    logic [OUT_USER_W-1:0] m_user_reg;
    logic                  m_last_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_step_reg <= step;
        if (s1_move && s1_valid_reg)
        begin
            m_data_reg <= s1_step_reg.rd_en ? rd_data_reg : '0;
            m_user_reg <= {s1_step_reg.is_pad, s1_step_reg.out_valid,
                           s1_step_reg.load_taken};
            m_last_reg <= s1_step_reg.row_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item did not reach stage 1");

    a_rd_data_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> $stable(rd_data_reg))
        else $error("line buffer data changed under a held item");

    a_pad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |-> (m_tdata == '0 && m_tuser[1]))
        else $error("padding item carries pixel data");

endmodule
